// File: sv/ddwd_pkg.sv
// ddwd_pkg: types, codes and helpers shared by the digitizer data word decoder.
// No dependencies.
`default_nettype none
package ddwd_pkg;

    localparam int WORD_W  = 32;
    localparam int VALUE_W = 19;
    localparam int CH_W    = 4;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 12;
    localparam int TYPES_W = 5;

    // readout word types
    localparam logic [3:0] TYPE_BLOCK_HDR = 4'd0;
    localparam logic [3:0] TYPE_BLOCK_TRL = 4'd1;
    localparam logic [3:0] TYPE_WINDOW    = 4'd4;
    localparam logic [3:0] TYPE_PULSE_RAW = 4'd6;
    localparam logic [3:0] TYPE_INTEGRAL  = 4'd7;
    localparam logic [3:0] TYPE_TIME      = 4'd8;
    localparam logic [3:0] TYPE_PED_PEAK  = 4'd10;

    // record kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_SAMPLE   = 3'd1;
    localparam logic [2:0] KIND_INTEGRAL = 3'd2;
    localparam logic [2:0] KIND_TIME     = 3'd3;
    localparam logic [2:0] KIND_PEDESTAL = 3'd4;
    localparam logic [2:0] KIND_PEAK     = 3'd5;

    // word status
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REJECT  = 2'd1;
    localparam logic [1:0] STAT_TRAILER = 2'd2;

    // types_seen bits
    localparam logic [TYPES_W-1:0] SEEN_WINDOW    = 5'h01;
    localparam logic [TYPES_W-1:0] SEEN_PULSE_RAW = 5'h02;
    localparam logic [TYPES_W-1:0] SEEN_INTEGRAL  = 5'h04;
    localparam logic [TYPES_W-1:0] SEEN_TIME      = 5'h08;
    localparam logic [TYPES_W-1:0] SEEN_PED_PEAK  = 5'h10;

    localparam logic [2:0] MODE_INVALID = 3'd0;
    localparam logic [2:0] MODE_1       = 3'd1;
    localparam logic [2:0] MODE_2       = 3'd2;
    localparam logic [2:0] MODE_3       = 3'd3;
    localparam logic [2:0] MODE_4       = 3'd4;
    localparam logic [2:0] MODE_7       = 3'd5;
    localparam logic [2:0] MODE_8       = 3'd6;

    typedef struct packed {
        logic [2:0]         kind;
        logic [VALUE_W-1:0] value;
        logic               inv;
        logic               ovf;
        logic [1:0]         pulse;
        logic [1:0]         quality;
    } t_rec;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        t_rec            rec0;
        t_rec            rec1;
        logic            has_second;
        logic [1:0]      status;
        logic [2:0]      mode;
    } t_entry;

    typedef struct packed {
        t_rec            rec;
        logic [CH_W-1:0] channel;
        logic [1:0]      status;
        logic [2:0]      mode;
        logic            last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [2:0] mode_of(input logic [TYPES_W-1:0] seen);
        logic [2:0] m;
        case (seen)
            SEEN_WINDOW:                                 m = MODE_1;
            SEEN_PULSE_RAW:                              m = MODE_2;
            SEEN_INTEGRAL | SEEN_TIME:                   m = MODE_3;
            SEEN_TIME | SEEN_PED_PEAK:                   m = MODE_4;
            SEEN_INTEGRAL | SEEN_TIME | SEEN_PED_PEAK:   m = MODE_7;
            SEEN_WINDOW | SEEN_TIME | SEEN_PED_PEAK:     m = MODE_8;
            default:                                     m = MODE_INVALID;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: sv/digitizer_data_word_decoder.sv
// digitizer_data_word_decoder: top level, front decoder, entry queue, output stage.
// Depends on ddwd_pkg, ddwd_front, ddwd_fifo, ddwd_back.
//
// One readout word is accepted per cycle while the two-entry queue has room.
// Each word yields one or two record beats (only sample pairs and pedestal/peak
// words can yield two); the output register issues one beat per cycle while
// i_ready is high, and the queue absorbs the burst.
// The first beat of a word is registered in the queue and then in the output
// register; a stall can hold it in either. The slot register may be
// written at any time through i_cfg_we/i_cfg_wdata.
`default_nettype none
module digitizer_data_word_decoder #(
    parameter int CHANNELS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ddwd_pkg::SLOT_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ddwd_pkg::WORD_W-1:0]       i_data_word,
    input  wire logic                              i_start_of_slot,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [2:0]                             o_record_kind,
    output logic [ddwd_pkg::CH_W-1:0]              o_channel,
    output logic [ddwd_pkg::VALUE_W-1:0]           o_value,
    output logic                                   o_sample_invalid,
    output logic                                   o_overflow_flag,
    output logic [1:0]                             o_pulse_number,
    output logic [1:0]                             o_quality,
    output logic [1:0]                             o_word_status,
    output logic [2:0]                             o_mode_code,
    output logic                                   o_last
);

    logic                push, pop;
    ddwd_pkg::t_entry    push_entry, head_entry;
    ddwd_pkg::t_q_status q_status;
    ddwd_pkg::t_result   res;

    ddwd_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_word     (i_data_word),
        .i_start_of_slot (i_start_of_slot),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    ddwd_fifo #(.DEPTH(2)) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    ddwd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (res)
    );

    assign o_record_kind    = res.rec.kind;
    assign o_channel        = res.channel;
    assign o_value          = res.rec.value;
    assign o_sample_invalid = res.rec.inv;
    assign o_overflow_flag  = res.rec.ovf;
    assign o_pulse_number   = res.rec.pulse;
    assign o_quality        = res.rec.quality;
    assign o_word_status    = res.status;
    assign o_mode_code      = res.mode;
    assign o_last           = res.last;

    // second record of a pair follows its first without a gap
    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_last)
        else $error("second record of a pair not issued");

    a_reject_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word_status == ddwd_pkg::STAT_REJECT |->
        o_record_kind == ddwd_pkg::KIND_NONE)
        else $error("record issued for a rejected word");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == ddwd_pkg::KIND_NONE |-> o_last)
        else $error("empty record not marked last");

    a_queue_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: sv/ddwd_front.sv
// ddwd_front: accepts readout words, tracks type/slot/window state and builds
// one queue entry per word. Depends on ddwd_pkg.
`default_nettype none
module ddwd_front #(
    parameter int CHANNELS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ddwd_pkg::SLOT_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ddwd_pkg::WORD_W-1:0]       i_data_word,
    input  wire logic                              i_start_of_slot,
    input  wire ddwd_pkg::t_q_status               i_q_status,
    output logic                                   o_push,
    output ddwd_pkg::t_entry                       o_entry
);

    localparam logic [ddwd_pkg::CH_W:0] CH_LIMIT = (ddwd_pkg::CH_W+1)'(CHANNELS);

    logic [ddwd_pkg::SLOT_W-1:0]  r_module_slot;
    logic [3:0]                   r_type,    n_type;
    logic                         r_match,   n_match;
    logic                         r_trailer, n_trailer;
    logic [ddwd_pkg::CH_W-1:0]    r_ch,      n_ch;
    logic [ddwd_pkg::CNT_W-1:0]   r_width,   n_width;
    logic [ddwd_pkg::CNT_W-1:0]   r_siw,     n_siw;
    logic [ddwd_pkg::TYPES_W-1:0] r_seen,    n_seen;
    logic [ddwd_pkg::SLOT_W-1:0]  r_hslot,   n_hslot;

    logic             hdr, inv1, inv2, drop, emit;
    logic [1:0]       status;
    logic [1:0]       rec_cnt;
    ddwd_pkg::t_rec   rec0, rec1;
    logic [ddwd_pkg::WORD_W-1:0] w;

    assign w       = i_data_word;
    assign hdr     = w[31];
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        n_type    = hdr ? w[30:27] : r_type;
        n_match   = i_start_of_slot ? 1'b0 : r_match;
        n_trailer = i_start_of_slot ? 1'b0 : r_trailer;
        n_siw     = i_start_of_slot ? '0 : r_siw;
        n_seen    = i_start_of_slot ? '0 : r_seen;
        n_ch      = r_ch;
        n_width   = r_width;
        n_hslot   = r_hslot;
        status    = ddwd_pkg::STAT_OK;
        rec_cnt   = 2'd0;
        rec0      = '0;
        rec1      = '0;
        inv1      = w[29];
        inv2      = w[13];
        drop      = 1'b0;
        if (!n_match && n_type != ddwd_pkg::TYPE_BLOCK_HDR) begin
            status = ddwd_pkg::STAT_REJECT;
        end else begin
            case (n_type)
                ddwd_pkg::TYPE_BLOCK_HDR: begin
                    if (hdr) begin
                        n_hslot = w[26:22];
                        n_match = (w[26:22] == r_module_slot);
                        if (w[26:22] != r_module_slot) status = ddwd_pkg::STAT_REJECT;
                    end
                end
                ddwd_pkg::TYPE_BLOCK_TRL: n_trailer = 1'b1;
                ddwd_pkg::TYPE_WINDOW, ddwd_pkg::TYPE_PULSE_RAW: begin
                    n_seen = n_seen | ((n_type == ddwd_pkg::TYPE_WINDOW) ?
                             ddwd_pkg::SEEN_WINDOW : ddwd_pkg::SEEN_PULSE_RAW);
                    if (hdr) begin
                        n_ch  = w[26:23];
                        n_siw = '0;
                        if (n_type == ddwd_pkg::TYPE_WINDOW) n_width = w[11:0];
                    end else begin
                        rec0.kind  = ddwd_pkg::KIND_SAMPLE;
                        rec0.value = inv1 ? '0 : ddwd_pkg::VALUE_W'(w[28:16]);
                        rec0.inv   = inv1;
                        rec0.ovf   = !inv1 && w[28];
                        rec1.kind  = ddwd_pkg::KIND_SAMPLE;
                        rec1.value = inv2 ? '0 : ddwd_pkg::VALUE_W'(w[12:0]);
                        rec1.inv   = inv2;
                        rec1.ovf   = !inv2 && w[12];
                        drop       = inv2 && ((n_siw + 12'd2) == r_width);
                        rec_cnt    = drop ? 2'd1 : 2'd2;
                        n_siw      = n_siw + (drop ? 12'd1 : 12'd2);
                    end
                end
                ddwd_pkg::TYPE_INTEGRAL: begin
                    n_seen        = n_seen | ddwd_pkg::SEEN_INTEGRAL;
                    n_ch          = w[26:23];
                    rec0.kind     = ddwd_pkg::KIND_INTEGRAL;
                    rec0.value    = w[18:0];
                    rec0.pulse    = w[22:21];
                    rec0.quality  = w[20:19];
                    rec_cnt       = 2'd1;
                end
                ddwd_pkg::TYPE_TIME: begin
                    n_seen        = n_seen | ddwd_pkg::SEEN_TIME;
                    n_ch          = w[26:23];
                    rec0.kind     = ddwd_pkg::KIND_TIME;
                    rec0.value    = ddwd_pkg::VALUE_W'(w[14:0]);
                    rec0.pulse    = w[22:21];
                    rec0.quality  = w[20:19];
                    rec_cnt       = 2'd1;
                end
                ddwd_pkg::TYPE_PED_PEAK: begin
                    n_seen        = n_seen | ddwd_pkg::SEEN_PED_PEAK;
                    n_ch          = w[26:23];
                    rec0.kind     = ddwd_pkg::KIND_PEDESTAL;
                    rec0.value    = ddwd_pkg::VALUE_W'(w[20:12]);
                    rec0.pulse    = w[22:21];
                    rec1.kind     = ddwd_pkg::KIND_PEAK;
                    rec1.value    = ddwd_pkg::VALUE_W'(w[11:0]);
                    rec1.pulse    = w[22:21];
                    rec_cnt       = 2'd2;
                end
                default: ;
            endcase
            if (status == ddwd_pkg::STAT_OK && n_trailer) status = ddwd_pkg::STAT_TRAILER;
        end
    end

    assign emit = (n_hslot == r_module_slot) && ({1'b0, n_ch} < CH_LIMIT)
                  && (rec_cnt != 2'd0);

    always_comb begin
        o_entry            = '0;
        o_entry.status     = status;
        o_entry.mode       = ddwd_pkg::mode_of(n_seen);
        if (emit) begin
            o_entry.channel    = n_ch;
            o_entry.rec0       = rec0;
            o_entry.rec1       = rec1;
            o_entry.has_second = (rec_cnt == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_slot <= '0;
            r_type        <= '0;
            r_match       <= 1'b0;
            r_trailer     <= 1'b0;
            r_ch          <= '0;
            r_width       <= '0;
            r_siw         <= '0;
            r_seen        <= '0;
            r_hslot       <= '0;
        end else begin
            if (i_cfg_we) r_module_slot <= i_cfg_wdata;
            if (o_push) begin
                r_type    <= n_type;
                r_match   <= n_match;
                r_trailer <= n_trailer;
                r_ch      <= n_ch;
                r_width   <= n_width;
                r_siw     <= n_siw;
                r_seen    <= n_seen;
                r_hslot   <= n_hslot;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/ddwd_fifo.sv
// ddwd_fifo: short flip-flop queue of decoded entries between front and back.
// Depends on ddwd_pkg.
`default_nettype none
module ddwd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ddwd_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output ddwd_pkg::t_entry      o_entry,
    output ddwd_pkg::t_q_status   o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ddwd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_entry        = r_mem[r_rd];
    assign o_status.full  = (r_cnt == FULL_CNT);
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

endmodule
`default_nettype wire

// File: sv/ddwd_back.sv
// ddwd_back: drains queue entries and issues one record beat per cycle, when
// not stalled by i_ready, through an output register. Depends on ddwd_pkg.
`default_nettype none
module ddwd_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ddwd_pkg::t_entry    i_entry,
    input  wire ddwd_pkg::t_q_status i_q_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output ddwd_pkg::t_result        o_result
);

    logic              r_valid, r_pend;
    ddwd_pkg::t_entry  r_hold;
    ddwd_pkg::t_result r_res;
    logic              load;

    assign load     = !r_valid || i_ready;
    assign o_pop    = load && !r_pend && !i_q_status.empty;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_q_status.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_entry.has_second;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_res.rec     <= r_hold.rec1;
                r_res.channel <= r_hold.channel;
                r_res.status  <= r_hold.status;
                r_res.mode    <= r_hold.mode;
                r_res.last    <= 1'b1;
            end else if (!i_q_status.empty) begin
                r_hold        <= i_entry;
                r_res.rec     <= i_entry.rec0;
                r_res.channel <= i_entry.channel;
                r_res.status  <= i_entry.status;
                r_res.mode    <= i_entry.mode;
                r_res.last    <= !i_entry.has_second;
            end
        end
    end

endmodule
`default_nettype wire

// File: tb/tb_digitizer_data_word_decoder.sv
// Self-checking bench for digitizer_data_word_decoder: directed and random readout
// words, checked beat by beat against a predictor of the record stream.
// Depends on ddwd_pkg and the digitizer_data_word_decoder RTL.
module tb_digitizer_data_word_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ddwd_pkg::*;

    localparam int CHANNELS    = 16;
    localparam int DRAIN_WAIT  = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;

    localparam logic [3:0] TYPE_EVENT_HDR = 4'd2;
    localparam logic [3:0] TYPE_FILLER    = 4'd15;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [18:0] value;
        logic        inv;
        logic        ovf;
        logic [1:0]  pulse;
        logic [1:0]  quality;
        logic [1:0]  status;
        logic [2:0]  mode;
        logic        last;
    } t_decoded_rec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_data_word;
    logic        i_start_of_slot;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_record_kind;
    logic [3:0]  o_channel;
    logic [18:0] o_value;
    logic        o_sample_invalid;
    logic        o_overflow_flag;
    logic [1:0]  o_pulse_number;
    logic [1:0]  o_quality;
    logic [1:0]  o_word_status;
    logic [2:0]  o_mode_code;
    logic        o_last;

    digitizer_data_word_decoder #(.CHANNELS(CHANNELS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_word      (i_data_word),
        .i_start_of_slot  (i_start_of_slot),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_record_kind    (o_record_kind),
        .o_channel        (o_channel),
        .o_value          (o_value),
        .o_sample_invalid (o_sample_invalid),
        .o_overflow_flag  (o_overflow_flag),
        .o_pulse_number   (o_pulse_number),
        .o_quality        (o_quality),
        .o_word_status    (o_word_status),
        .o_mode_code      (o_mode_code),
        .o_last           (o_last)
    );

    // decoder state mirror
    logic [4:0]  slot_cfg;
    logic [3:0]  cur_type;
    logic        matched;
    logic        trl_seen;
    logic [3:0]  cur_ch;
    logic [11:0] win_len;
    logic [11:0] win_count;
    logic [4:0]  seen;
    logic [4:0]  hdr_slot;

    t_decoded_rec pending_recs[$];
    t_decoded_rec step_recs[2];
    int           step_n;

    int errors        = 0;
    int words_sent    = 0;
    int decoded_words = 0;
    int recs_checked  = 0;
    int slot_writes   = 0;
    int idle_cycles   = 0;
    int sink_hold_len = 0;
    int hold_left     = 0;
    bit src_idle_on   = 1'b1;
    bit sink_idle_on  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [2:0] mode_from_seen(input logic [4:0] s);
        case (s)
            SEEN_WINDOW:                               return MODE_1;
            SEEN_PULSE_RAW:                            return MODE_2;
            SEEN_INTEGRAL | SEEN_TIME:                 return MODE_3;
            SEEN_TIME | SEEN_PED_PEAK:                 return MODE_4;
            SEEN_INTEGRAL | SEEN_TIME | SEEN_PED_PEAK: return MODE_7;
            SEEN_WINDOW | SEEN_TIME | SEEN_PED_PEAK:   return MODE_8;
            default:                                   return MODE_INVALID;
        endcase
    endfunction

    function automatic void add_rec(input logic [2:0] kind, input logic [18:0] val,
                                    input logic inv, input logic ovf,
                                    input logic [1:0] pn, input logic [1:0] q);
        if (slot_cfg != hdr_slot || int'(cur_ch) >= CHANNELS || step_n >= 2)
            return;
        step_recs[step_n] = '{kind: kind, channel: cur_ch, value: val, inv: inv, ovf: ovf,
                              pulse: pn, quality: q, status: STAT_OK, mode: MODE_INVALID,
                              last: 1'b0};
        step_n++;
    endfunction

    function automatic void decode_word(input logic [31:0] w, input logic sos);
        logic        hdr;
        logic [1:0]  status;
        logic [11:0] prev_count;
        logic        inv1;
        logic        inv2;
        logic [12:0] s1;
        logic [12:0] s2;
        hdr    = w[31];
        status = STAT_OK;
        step_n = 0;
        if (sos) begin
            seen      = '0;
            matched   = 1'b0;
            trl_seen  = 1'b0;
            win_count = '0;
        end
        if (hdr)
            cur_type = w[30:27];
        if (!matched && cur_type != TYPE_BLOCK_HDR) begin
            status = STAT_REJECT;
        end else begin
            case (cur_type)
                TYPE_BLOCK_HDR: begin
                    if (hdr) begin
                        hdr_slot = w[26:22];
                        matched  = (hdr_slot == slot_cfg);
                        if (!matched)
                            status = STAT_REJECT;
                    end
                end
                TYPE_BLOCK_TRL: trl_seen = 1'b1;
                TYPE_WINDOW, TYPE_PULSE_RAW: begin
                    seen |= (cur_type == TYPE_WINDOW) ? SEEN_WINDOW : SEEN_PULSE_RAW;
                    if (hdr) begin
                        cur_ch    = w[26:23];
                        win_count = '0;
                        if (cur_type == TYPE_WINDOW)
                            win_len = w[11:0];
                    end else begin
                        inv1       = w[29];
                        inv2       = w[13];
                        s1         = inv1 ? 13'd0 : w[28:16];
                        s2         = inv2 ? 13'd0 : w[12:0];
                        prev_count = win_count;
                        add_rec(KIND_SAMPLE, 19'(s1), inv1, s1[12], 2'd0, 2'd0);
                        win_count++;
                        // invalid trailing sample of a full window is dropped
                        if (!(inv2 && prev_count + 12'd2 == win_len)) begin
                            add_rec(KIND_SAMPLE, 19'(s2), inv2, s2[12], 2'd0, 2'd0);
                            win_count++;
                        end
                    end
                end
                TYPE_INTEGRAL: begin
                    seen  |= SEEN_INTEGRAL;
                    cur_ch = w[26:23];
                    add_rec(KIND_INTEGRAL, w[18:0], 1'b0, 1'b0, w[22:21], w[20:19]);
                end
                TYPE_TIME: begin
                    seen  |= SEEN_TIME;
                    cur_ch = w[26:23];
                    add_rec(KIND_TIME, 19'(w[14:0]), 1'b0, 1'b0, w[22:21], w[20:19]);
                end
                TYPE_PED_PEAK: begin
                    seen  |= SEEN_PED_PEAK;
                    cur_ch = w[26:23];
                    add_rec(KIND_PEDESTAL, 19'(w[20:12]), 1'b0, 1'b0, w[22:21], 2'd0);
                    add_rec(KIND_PEAK, 19'(w[11:0]), 1'b0, 1'b0, w[22:21], 2'd0);
                end
                default: ;
            endcase
            if (status == STAT_OK && trl_seen)
                status = STAT_TRAILER;
        end
        if (step_n == 0) begin
            step_recs[0] = '0;
            step_n       = 1;
        end
        for (int k = 0; k < step_n; k++) begin
            step_recs[k].status = status;
            step_recs[k].mode   = mode_from_seen(seen);
            step_recs[k].last   = (k == step_n - 1);
            pending_recs.insert(pending_recs.size(), step_recs[k]);
        end
        if (status != STAT_REJECT)
            decoded_words++;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_decoded_rec want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_recs.size() == 0) begin
                $error("unexpected record beat: kind %0d value %0h", o_record_kind, o_value);
                errors++;
            end else begin
                want = pending_recs.pop_front();
                check_field("record_kind", want.kind, o_record_kind);
                check_field("channel", want.channel, o_channel);
                check_field("value", want.value, o_value);
                check_field("sample_invalid", want.inv, o_sample_invalid);
                check_field("overflow_flag", want.ovf, o_overflow_flag);
                check_field("pulse_number", want.pulse, o_pulse_number);
                check_field("quality", want.quality, o_quality);
                check_field("word_status", want.status, o_word_status);
                check_field("mode_code", want.mode, o_mode_code);
                check_field("last", want.last, o_last);
                recs_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold_len > 0) begin
            hold_left     = sink_hold_len;
            sink_hold_len = 0;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= !(sink_idle_on && $urandom_range(99) < 37);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] block_hdr(input logic [4:0] slot);
        return {1'b1, TYPE_BLOCK_HDR, slot, 22'($urandom)};
    endfunction

    function automatic logic [31:0] window_hdr(input logic [3:0] ch, input logic [11:0] width);
        return {1'b1, TYPE_WINDOW, ch, 11'($urandom), width};
    endfunction

    function automatic logic [31:0] pair_word(input logic inv1, input logic [12:0] s1,
                                              input logic inv2, input logic [12:0] s2);
        return {1'b0, 1'($urandom), inv1, s1, 2'($urandom), inv2, s2};
    endfunction

    function automatic logic [31:0] random_pair(input logic force_inv2);
        return pair_word($urandom_range(5) == 0, 13'($urandom),
                         force_inv2 || $urandom_range(5) == 0, 13'($urandom));
    endfunction

    function automatic logic [3:0] unused_type();
        logic [3:0] t;
        do
            t = 4'($urandom);
        while (t == TYPE_BLOCK_HDR || t == TYPE_BLOCK_TRL || t == TYPE_WINDOW ||
               t == TYPE_PULSE_RAW || t == TYPE_INTEGRAL || t == TYPE_TIME ||
               t == TYPE_PED_PEAK);
        return t;
    endfunction

    // called and returns at a falling edge
    task automatic send_word(input logic [31:0] word, input logic sos);
        if (src_idle_on && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            do
                @(negedge i_clk);
            while ($urandom_range(99) < 37);
        end
        i_valid         <= 1'b1;
        i_data_word     <= word;
        i_start_of_slot <= sos;
        do
            @(posedge i_clk);
        while (!o_ready);
        decode_word(word, sos);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_recs.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_slot(input logic [4:0] slot);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= slot;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        slot_cfg  = slot;
        slot_writes++;
    endtask

    task automatic send_event();
        logic [4:0] slot;
        logic [3:0] t;
        int         k;
        int         n;
        int         i;
        int         width;
        slot = ($urandom_range(9) == 0) ? 5'($urandom) : slot_cfg;
        send_word(block_hdr(slot), $urandom_range(2) == 0);
        repeat ($urandom_range(1, 4)) begin
            k = $urandom_range(5);
            if (k <= 1) begin
                if (k == 0) begin
                    width = ($urandom_range(15) == 0) ? $urandom_range(4095)
                                                      : $urandom_range(1, 10);
                    send_word(window_hdr(4'($urandom), 12'(width)), 1'b0);
                    n = (width > 16) ? $urandom_range(1, 6) : (width + 1) / 2;
                end else begin
                    send_word({1'b1, TYPE_PULSE_RAW, 27'($urandom)}, 1'b0);
                    n = $urandom_range(1, 4);
                end
                for (i = 0; i < n; i++)
                    send_word(random_pair(k == 0 && i == n - 1 && $urandom_range(1) == 1),
                              1'b0);
            end else begin
                t = (k == 2) ? TYPE_INTEGRAL : (k == 3) ? TYPE_TIME :
                    (k == 4) ? TYPE_PED_PEAK : unused_type();
                send_word({1'b1, t, 27'($urandom)}, 1'b0);
                repeat ($urandom_range(3)) send_word({1'b0, 31'($urandom)}, 1'b0);
            end
        end
        if ($urandom_range(4) != 0)
            send_word({1'b1, TYPE_BLOCK_TRL, 27'($urandom)}, 1'b0);
        if ($urandom_range(3) == 0)
            send_word({1'b0, 31'($urandom)}, 1'b0);
    endtask

    task automatic test_directed_words();
        send_word(32'h0000_0000, 1'b0);
        send_word(block_hdr(5'd5), 1'b1);
        send_word({1'b1, TYPE_INTEGRAL, 27'h7FF_FFFF}, 1'b0);
        send_word(block_hdr(slot_cfg), 1'b0);
        send_word(window_hdr(4'hF, 12'd4), 1'b0);
        send_word(pair_word(1'b0, 13'h1FFF, 1'b0, 13'h1FFF), 1'b0);
        send_word(pair_word(1'b1, 13'h1FFF, 1'b1, 13'h1FFF), 1'b0);
        send_word(pair_word(1'b0, 13'h0000, 1'b0, 13'h0000), 1'b0);
        send_word({1'b1, TYPE_PULSE_RAW, 4'h0, 23'h0}, 1'b0);
        send_word(pair_word(1'b1, 13'h0000, 1'b0, 13'h0FFF), 1'b0);
        send_word({1'b1, TYPE_INTEGRAL, 27'h7FF_FFFF}, 1'b0);
        send_word({1'b0, 31'h0}, 1'b0);
        send_word({1'b1, TYPE_TIME, 27'h7FF_FFFF}, 1'b0);
        send_word({1'b0, 31'h7FFF_FFFF}, 1'b0);
        send_word({1'b1, TYPE_PED_PEAK, 27'h7FF_FFFF}, 1'b0);
        send_word({1'b0, 31'($urandom)}, 1'b0);
        send_word({1'b1, TYPE_FILLER, 27'($urandom)}, 1'b0);
        send_word({1'b1, TYPE_EVENT_HDR, 27'($urandom)}, 1'b0);
        send_word({1'b1, unused_type(), 27'($urandom)}, 1'b0);
        send_word({1'b1, TYPE_BLOCK_TRL, 27'($urandom)}, 1'b0);
        send_word({1'b1, TYPE_TIME, 27'($urandom)}, 1'b0);
        // slot start drops the match, so this continuation is rejected
        send_word({1'b0, 31'($urandom)}, 1'b1);
        send_word(block_hdr(slot_cfg), 1'b0);
        send_word(window_hdr(4'h3, 12'hFFF), 1'b0);
        settle();
    endtask

    // slot register changed after a match: records stay suppressed until a new header
    task automatic test_slot_rewrite();
        write_slot(5'd31);
        send_word(block_hdr(5'd31), 1'b1);
        send_word({1'b1, TYPE_INTEGRAL, 27'($urandom)}, 1'b0);
        write_slot(5'd7);
        send_word({1'b1, TYPE_TIME, 27'($urandom)}, 1'b0);
        send_word(window_hdr(4'($urandom), 12'd6), 1'b0);
        repeat (3) send_word(random_pair(1'b1), 1'b0);
        send_word(block_hdr(5'd7), 1'b0);
        send_word({1'b1, TYPE_PED_PEAK, 27'($urandom)}, 1'b0);
        send_word({1'b0, 31'($urandom)}, 1'b0);
        settle();
    endtask

    task automatic test_output_stall();
        sink_hold_len = HOLD_CYCLES;
        send_word(block_hdr(slot_cfg), 1'b1);
        send_word({1'b1, TYPE_PULSE_RAW, 27'($urandom)}, 1'b0);
        repeat (25) send_word(random_pair(1'b0), 1'b0);
        settle();
    endtask

    task automatic test_random_events(input logic [4:0] slot, input int target);
        int start;
        write_slot(slot);
        start = decoded_words;
        while (decoded_words - start < target) begin
            if ($urandom_range(6) == 0)
                repeat ($urandom_range(1, 3))
                    send_word(32'($urandom), $urandom_range(7) == 0);
            else
                send_event();
        end
    endtask

    // random events with both sides always ready
    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_events(5'($urandom), 300);
        settle();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_data_word     = '0;
        i_start_of_slot = 1'b0;
        slot_cfg        = '0;
        cur_type        = '0;
        matched         = 1'b0;
        trl_seen        = 1'b0;
        cur_ch          = '0;
        win_len         = '0;
        win_count       = '0;
        seen            = '0;
        hdr_slot        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_words();
        test_slot_rewrite();
        test_output_stall();
        test_random_events(5'd0, 300);
        test_random_events(5'd31, 300);
        test_back_to_back();
        test_random_events(5'($urandom), 300);
        test_random_events(5'($urandom), 300);

        settle();
        if (pending_recs.size() != 0) begin
            $error("%0d expected records never arrived", pending_recs.size());
            errors++;
        end
        $display("run covered %0d words (%0d decoded), %0d record beats checked,",
                 words_sent, decoded_words, recs_checked);
        $display("%0d slot settings, a long output hold-off and a stretch with no idling",
                 slot_writes);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
sv/ddwd_pkg.sv
sv/ddwd_front.sv
sv/ddwd_fifo.sv
sv/ddwd_back.sv
sv/digitizer_data_word_decoder.sv
tb/tb_digitizer_data_word_decoder.sv
